FILE: hdl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants for the two-stack memory
// Operation and status codes, the command passed from the front part to the
// back part, and the capacity register width and reset value.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_LOWER = 2'd0,
    OP_PUSH_UPPER = 2'd1,
    OP_POP_LOWER  = 2'd2,
    OP_POP_UPPER  = 2'd3
  } tss_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } tss_status_e;

  // Control part of one command for the back part.
  typedef struct packed {
    logic        wr;
    logic        rd;
    tss_status_e status;
  } tss_cmd_t;

endpackage

FILE: hdl/tss_front.sv
// ----------------------------------------------------------------------------
// tss_front: operation decode and stack pointers
// Holds the capacity register and both stack counts, checks each operation
// for overflow or underflow and turns it into a memory command.
// ----------------------------------------------------------------------------
module tss_front import tss_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic signed [WORD_W-1:0] push_value_i,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_data_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output tss_cmd_t                 cmd_o,
  output logic [AW-1:0]            addr_o,
  output logic [WORD_W-1:0]        word_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > CAP_W) ? CntW : CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic [CntW-1:0]  lower_q, lower_d;
  logic [CntW-1:0]  upper_q, upper_d;
  logic [CmpW-1:0]  cap_ext, depth_c, eff_wide;
  logic [CntW-1:0]  eff;
  logic [CntW:0]    used;
  logic             full;
  logic [CntW-1:0]  addr_wide;
  logic             accept;
  tss_op_e          op;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;
  assign word_o     = push_value_i;
  assign op         = tss_op_e'(opcode_i);

  // Effective capacity: zero reads as one, anything above DEPTH saturates.
  assign cap_ext = CmpW'(cap_q);
  assign depth_c = CmpW'(DEPTH);
  always_comb begin
    if (cap_ext == '0) begin
      eff_wide = CmpW'(1);
    end else if (cap_ext > depth_c) begin
      eff_wide = depth_c;
    end else begin
      eff_wide = cap_ext;
    end
  end
  assign eff  = eff_wide[CntW-1:0];
  assign used = {1'b0, lower_q} + {1'b0, upper_q};
  assign full = used >= {1'b0, eff};

  always_comb begin
    lower_d    = lower_q;
    upper_d    = upper_q;
    cmd_o.wr   = 1'b0;
    cmd_o.rd   = 1'b0;
    cmd_o.status = ST_OK;
    addr_wide  = '0;
    case (op)
      OP_PUSH_LOWER: begin
        if (full) begin
          cmd_o.status = ST_OVERFLOW;
        end else begin
          cmd_o.wr  = 1'b1;
          addr_wide = lower_q;
          lower_d   = lower_q + CntW'(1);
        end
      end
      OP_PUSH_UPPER: begin
        if (full) begin
          cmd_o.status = ST_OVERFLOW;
        end else begin
          cmd_o.wr  = 1'b1;
          upper_d   = upper_q + CntW'(1);
          addr_wide = eff - upper_d;
        end
      end
      OP_POP_LOWER: begin
        if (lower_q == '0) begin
          cmd_o.status = ST_UNDERFLOW;
        end else begin
          cmd_o.rd  = 1'b1;
          lower_d   = lower_q - CntW'(1);
          addr_wide = lower_d;
        end
      end
      OP_POP_UPPER: begin
        if (upper_q == '0) begin
          cmd_o.status = ST_UNDERFLOW;
        end else begin
          cmd_o.rd  = 1'b1;
          addr_wide = eff - upper_q;
          upper_d   = upper_q - CntW'(1);
        end
      end
      default: begin
        cmd_o.status = ST_OK;
      end
    endcase
  end

  assign addr_o = addr_wide[AW-1:0];

  // A capacity write empties both stacks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      lower_q <= '0;
      upper_q <= '0;
    end else if (cfg_we_i) begin
      cap_q   <= cfg_data_i;
      lower_q <= '0;
      upper_q <= '0;
    end else if (accept) begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

endmodule

FILE: hdl/tss_fifo.sv
// ----------------------------------------------------------------------------
// tss_fifo: two-entry command queue
// Decouples the decode part from the memory part so each can stall alone.
// ----------------------------------------------------------------------------
module tss_fifo import tss_pkg::*; #(
  parameter int W = 46
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/tss_back.sv
// ----------------------------------------------------------------------------
// tss_back: shared memory and result register
// Executes one queued command per cycle against the single-port memory, but
// none while the receiver stalls a held result, which it keeps until taken.
// ----------------------------------------------------------------------------
module tss_back import tss_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  output logic                      q_pop_o,
  input  tss_cmd_t                  cmd_i,
  input  logic [AW-1:0]             addr_i,
  input  logic [WORD_W-1:0]         word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [WORD_W-1:0]  pop_value_o,
  output logic [1:0]                status_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic              sel_q;
  tss_status_e       status_q;
  logic              valid_q;

  assign q_pop_o = !q_empty_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (cmd_i.wr) begin
        mem[addr_i] <= word_i;
      end
      if (cmd_i.rd) begin
        rd_q <= mem[addr_i];
      end
      sel_q    <= cmd_i.rd;
      status_q <= cmd_i.status;
    end
  end

  assign out_valid_o = valid_q;
  assign pop_value_o = sel_q ? rd_q : '0;
  assign status_o    = status_q;

endmodule

FILE: hdl/two_stacks_shared_memory.sv
// ----------------------------------------------------------------------------
// two_stacks_shared_memory: two LIFO stacks in one shared memory
// The lower stack grows up from entry 0, the upper one down from capacity-1.
// ----------------------------------------------------------------------------
// Usage: each input word carries an opcode (push lower, push upper, pop
// lower, pop upper) and a push value. A word is taken at a clock edge with
// in_valid_i high and in_stall_o low. Each input word yields exactly one
// output word (pop_value_o, status_o), offered on out_valid_o and taken at
// an edge where out_stall_i is low.
// An accepted word goes into the command queue and then into the result
// register. Sustained throughput is one word per cycle while out_stall_i
// is low, set by the single read/write port of the back part's shared memory.
// The user writes the capacity register through cfg_valid_i/cfg_ready_o
// only while the block is idle (not enforced); a write empties both stacks.
// Reset clears both stack counts and sets the capacity to 1024; memory
// contents stay undefined, but no pop can reach an unwritten entry.
// When the receiver stalls, the result register holds and the two-word
// command queue fills; once it is full, in_stall_o rises.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory import tss_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic signed [WORD_W-1:0] push_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] pop_value_o,
  output logic [1:0]               status_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CAP_W-1:0]         cfg_data_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CmdW = $bits(tss_cmd_t);
  localparam int QW = CmdW + AW + WORD_W;

  // The register is always writable; the user makes writes only while idle, as the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  logic              q_push, q_pop, q_full, q_empty;
  tss_cmd_t          f_cmd, b_cmd;
  logic [AW-1:0]     f_addr, b_addr;
  logic [WORD_W-1:0] f_word, b_word;
  logic [QW-1:0]     q_in, q_out;

  // Front: decode and pointer update.
  tss_front #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .push_value_i (push_value_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .cmd_o        (f_cmd),
    .addr_o       (f_addr),
    .word_o       (f_word)
  );

  assign q_in = {f_cmd, f_addr, f_word};

  // Command queue between the two parts.
  tss_fifo #(
    .W (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign b_cmd  = tss_cmd_t'(q_out[QW-1 -: CmdW]);
  assign b_addr = q_out[WORD_W +: AW];
  assign b_word = q_out[WORD_W-1:0];

  // Back: memory access and result register.
  tss_back #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .cmd_i       (b_cmd),
    .addr_i      (b_addr),
    .word_i      (b_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pop_value_o (pop_value_o),
    .status_o    (status_o)
  );

  // The front never writes into a full queue.
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("command queue overrun");

  // The back never takes a command from an empty queue.
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("command queue underrun");

  // A refused operation always reports a zero word.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (pop_value_o == '0))
    else $error("nonzero word with error status");

  // A queued command reaches the output register in the cycle after it is taken.
  a_pop_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o) else $error("result not shown after issue");

endmodule
